// ===== rtl/hcc_pkg.sv =====
package hcc_pkg;

  // Field widths of the conversion words.
  localparam int unsigned CoordW    = 16;
  localparam int unsigned IndexW    = 2 * CoordW;
  localparam int unsigned OrderW    = 5;
  localparam int unsigned MaxOrder  = 16;

  // Pipeline shape: sixteen curve levels spread over four register stages.
  localparam int unsigned LvlW           = 4;
  localparam int unsigned LevelsPerStage = 4;
  localparam int unsigned NumStages      = 4;
  localparam int unsigned StageW         = 2;

  // Configuration register map.
  localparam int unsigned DataW     = 32;
  localparam int unsigned AddrW     = 3;
  localparam logic        RegCurveOrder = 1'b0;

  // Direction of one conversion.
  typedef enum logic {
    HCC_ENCODE = 1'b0,
    HCC_DECODE = 1'b1
  } hcc_cmd_e;

  // Word that travels down the pipeline. For encoding, x and y are the working
  // coordinates and acc gathers the index. For decoding, acc holds the index and
  // x and y gather the coordinates.
  typedef struct packed {
    hcc_cmd_e            cmd;
    logic [CoordW-1:0]   x;
    logic [CoordW-1:0]   y;
    logic [IndexW-1:0]   acc;
  } hcc_word_t;

  // One encoding level at bit position b, taking the quadrant from the top down.
  function automatic hcc_word_t hcc_enc_level(hcc_word_t w, logic [LvlW-1:0] b);
    hcc_word_t         r;
    logic              rx;
    logic              ry;
    logic [CoordW-1:0] t;
    r  = w;
    rx = w.x[b];
    ry = w.y[b];
    r.acc[{b, 1'b0} +: 2] = {rx, rx ^ ry};
    if (!ry) begin
      if (rx) begin
        r.x = ~r.x;
        r.y = ~r.y;
      end
      t   = r.x;
      r.x = r.y;
      r.y = t;
    end
    return r;
  endfunction

  // One decoding level at bit position l, building the coordinates bottom up.
  function automatic hcc_word_t hcc_dec_level(hcc_word_t w, logic [LvlW-1:0] l);
    hcc_word_t         r;
    logic              rx;
    logic              ry;
    logic [CoordW-1:0] low_mask;
    logic [CoordW-1:0] t;
    r        = w;
    rx       = w.acc[{l, 1'b1}];
    ry       = w.acc[{l, 1'b0}] ^ rx;
    low_mask = (CoordW'(1) << l) - CoordW'(1);
    if (!ry) begin
      if (rx) begin
        r.x = r.x ^ low_mask;
        r.y = r.y ^ low_mask;
      end
      t   = r.x;
      r.x = r.y;
      r.y = t;
    end
    r.x[l] = rx;
    r.y[l] = ry;
    return r;
  endfunction

endpackage

// ===== rtl/hcc_in_if.sv =====
interface hcc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [hcc_pkg::CoordW-1:0]   in_x;
  logic [hcc_pkg::CoordW-1:0]   in_y;
  logic [hcc_pkg::IndexW-1:0]   in_index;

  modport source (output valid, output cmd, output in_x, output in_y, output in_index,
                  input ready);
  modport sink   (input valid, input cmd, input in_x, input in_y, input in_index,
                  output ready);
endinterface

// ===== rtl/hcc_out_if.sv =====
interface hcc_out_if;
  logic                         valid;
  logic                         ready;
  logic [hcc_pkg::CoordW-1:0]   out_x;
  logic [hcc_pkg::CoordW-1:0]   out_y;
  logic [hcc_pkg::IndexW-1:0]   out_index;

  modport source (output valid, output out_x, output out_y, output out_index,
                  input ready);
  modport sink   (input valid, input out_x, input out_y, input out_index,
                  output ready);
endinterface

// ===== rtl/hcc_cfg.sv =====
module hcc_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hcc_pkg::AddrW-1:0]    paddr,
  input  logic [hcc_pkg::DataW-1:0]    pwdata,
  output logic [hcc_pkg::DataW-1:0]    prdata,
  output logic                         pready,
  output logic [hcc_pkg::OrderW-1:0]   order_o
);

  logic [hcc_pkg::OrderW-1:0] curve_order_q;
  logic [hcc_pkg::OrderW-1:0] curve_order_d;
  logic                       reg_sel;

  // Registers sit on word addresses, so the index is the bit above the byte lane.
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;

  // Register write in the access phase.
  always_comb begin
    curve_order_d = curve_order_q;
    if (psel && penable && pwrite && (reg_sel == hcc_pkg::RegCurveOrder)) begin
      curve_order_d = pwdata[hcc_pkg::OrderW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_order_q <= hcc_pkg::OrderW'(hcc_pkg::MaxOrder);
    end else begin
      curve_order_q <= curve_order_d;
    end
  end

  // Read back the stored value; unmapped addresses read as zero.
  always_comb begin
    prdata = '0;
    if (reg_sel == hcc_pkg::RegCurveOrder) begin
      prdata = hcc_pkg::DataW'(curve_order_q);
    end
  end

  // The order used by the datapath saturates at the deepest supported curve.
  assign order_o = (curve_order_q > hcc_pkg::OrderW'(hcc_pkg::MaxOrder)) ?
                   hcc_pkg::OrderW'(hcc_pkg::MaxOrder) : curve_order_q;

endmodule

// ===== rtl/hcc_stage.sv =====
module hcc_stage (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [hcc_pkg::OrderW-1:0]   order_i,
  input  logic [hcc_pkg::StageW-1:0]   stage_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  hcc_pkg::hcc_word_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output hcc_pkg::hcc_word_t           out_data_o
);

  logic               valid_q;
  hcc_pkg::hcc_word_t data_q;
  hcc_pkg::hcc_word_t data_d;

  // Four curve levels per stage. Decoding runs up from the low levels and
  // encoding runs down from the high ones, so level l pairs with level 15 - l.
  always_comb begin
    logic [hcc_pkg::LvlW-1:0] lvl;
    hcc_pkg::hcc_word_t       w;
    w = in_data_i;
    for (int j = 0; j < hcc_pkg::LevelsPerStage; j++) begin
      lvl = {stage_i, 2'b00} + hcc_pkg::LvlW'(j);
      if (w.cmd == hcc_pkg::HCC_DECODE) begin
        if ({1'b0, lvl} < order_i) begin
          w = hcc_pkg::hcc_dec_level(w, lvl);
        end
      end else begin
        if ({1'b0, ~lvl} < order_i) begin
          w = hcc_pkg::hcc_enc_level(w, ~lvl);
        end
      end
    end
    data_d = w;
  end

  // The stage takes a new word whenever its register is empty or being drained.
  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== rtl/hilbert_curve_codec_top.sv =====
// Hilbert curve codec: each word converts grid coordinates to a curve index
// (cmd low) or an index to coordinates (cmd high) for the curve order held in
// the curve_order register, saturated at 16. The datapath is four register
// stages of four curve levels each, so one word is accepted every cycle while
// the output is not stalled, and its result comes from the last stage register;
// back-pressure on the output stalls the stages in place without losing or
// repeating a word. Change curve_order only while no conversion is in flight.
module hilbert_curve_codec_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  hcc_in_if.sink                       in_i,
  hcc_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hcc_pkg::AddrW-1:0]    paddr,
  input  logic [hcc_pkg::DataW-1:0]    pwdata,
  output logic [hcc_pkg::DataW-1:0]    prdata,
  output logic                         pready
);

  logic [hcc_pkg::OrderW-1:0] order;
  logic                       pipe_valid [hcc_pkg::NumStages+1];
  logic                       pipe_ready [hcc_pkg::NumStages+1];
  hcc_pkg::hcc_word_t         pipe_data  [hcc_pkg::NumStages+1];
  hcc_pkg::hcc_word_t         last;

  hcc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .order_o (order)
  );

  // Build the entry word: decoding carries the index and starts the point at the
  // origin, encoding carries the point and starts the index from zero.
  always_comb begin
    pipe_data[0].cmd = hcc_pkg::hcc_cmd_e'(in_i.cmd);
    pipe_data[0].x   = (in_i.cmd == hcc_pkg::HCC_DECODE) ? '0 : in_i.in_x;
    pipe_data[0].y   = (in_i.cmd == hcc_pkg::HCC_DECODE) ? '0 : in_i.in_y;
    pipe_data[0].acc = (in_i.cmd == hcc_pkg::HCC_DECODE) ? in_i.in_index : '0;
  end

  assign pipe_valid[0] = in_i.valid;
  assign in_i.ready    = pipe_ready[0];

  for (genvar k = 0; k < hcc_pkg::NumStages; k++) begin : g_stage
    hcc_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .order_i     (order),
      .stage_i     (hcc_pkg::StageW'(k)),
      .in_valid_i  (pipe_valid[k]),
      .in_ready_o  (pipe_ready[k]),
      .in_data_i   (pipe_data[k]),
      .out_valid_o (pipe_valid[k+1]),
      .out_ready_i (pipe_ready[k+1]),
      .out_data_o  (pipe_data[k+1])
    );
  end

  // The last stage register is the output register.
  assign last                         = pipe_data[hcc_pkg::NumStages];
  assign out_o.valid                  = pipe_valid[hcc_pkg::NumStages];
  assign pipe_ready[hcc_pkg::NumStages] = out_o.ready;

  // Only the fields of the chosen direction are reported; the others read zero.
  always_comb begin
    if (last.cmd == hcc_pkg::HCC_DECODE) begin
      out_o.out_x     = last.x;
      out_o.out_y     = last.y;
      out_o.out_index = '0;
    end else begin
      out_o.out_x     = '0;
      out_o.out_y     = '0;
      out_o.out_index = last.acc;
    end
  end

endmodule

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hcc_pkg::*;

  // One conversion request as the source side offers it.
  typedef struct {
    hcc_cmd_e          cmd;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [IndexW-1:0] index;
    int unsigned       gap;
    bit                wait_drain;
  } conv_req_t;

  // One conversion result, in the order of the output word.
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [IndexW-1:0] index;
  } conv_res_t;

  localparam logic [AddrW-1:0] OrderAddr  = AddrW'(4 * RegCurveOrder);
  localparam int unsigned      FlushTicks = 8;
  localparam int unsigned      RandPerSet = 120;
  localparam int unsigned      HoldStart  = 500;
  localparam int unsigned      HoldTicks  = 300;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;

  hcc_in_if  conv_in ();
  hcc_out_if conv_out ();

  conv_req_t   pending_q[$];
  conv_res_t   expected_q[$];
  logic [4:0]  order_reg;
  int unsigned fail_cnt;
  int unsigned accepted_cnt;
  bit          in_fire;
  bit          out_fire;
  bit          src_idle_on;
  bit          snk_idle_on;
  bit          snk_hold;

  hilbert_curve_codec_top u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (conv_in),
    .out_o   (conv_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Expected result of one conversion at the given register setting.
  function automatic conv_res_t hilbert_convert(logic [4:0] ord, hcc_cmd_e cmd,
                                                logic [CoordW-1:0] xi,
                                                logic [CoordW-1:0] yi,
                                                logic [IndexW-1:0] di);
    conv_res_t         r;
    int                m;
    int                b;
    logic [CoordW-1:0] cmask;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] t;
    logic [31:0]       px;
    logic [31:0]       py;
    logic [31:0]       s;
    logic [31:0]       tmp;
    logic [31:0]       dd;
    logic [63:0]       dmask;
    logic              rx;
    logic              ry;
    m     = (ord > MaxOrder) ? MaxOrder : ord;
    r     = '0;
    cmask = CoordW'((32'd1 << m) - 32'd1);
    if (cmd == HCC_ENCODE) begin
      // Top level first: take the quadrant, then reflect and swap the rest.
      x = xi & cmask;
      y = yi & cmask;
      for (b = m - 1; b >= 0; b--) begin
        rx      = x[b];
        ry      = y[b];
        r.index = r.index | (32'({rx, rx ^ ry}) << (2 * b));
        if (!ry) begin
          if (rx) begin
            x = ~x & cmask;
            y = ~y & cmask;
          end
          t = x;
          x = y;
          y = t;
        end
      end
    end else begin
      // Bottom level first: grow the point one sub-square at a time.
      dmask = (64'd1 << (2 * m)) - 64'd1;
      dd    = di & dmask[31:0];
      px    = '0;
      py    = '0;
      for (b = 0; b < m; b++) begin
        s  = 32'd1 << b;
        rx = dd[1];
        ry = dd[0] ^ rx;
        if (!ry) begin
          if (rx) begin
            px = s - 32'd1 - px;
            py = s - 32'd1 - py;
          end
          tmp = px;
          px  = py;
          py  = tmp;
        end
        px = px + (rx ? s : 32'd0);
        py = py + (ry ? s : 32'd0);
        dd = dd >> 2;
      end
      r.x = px[CoordW-1:0];
      r.y = py[CoordW-1:0];
    end
    return r;
  endfunction

  // Random wait in cycles: with waits on, roughly half the words go back to back; with them off, all do.
  function automatic int unsigned draw_wait(bit on);
    if (on && $urandom_range(0, 1) == 1) begin
      return $urandom_range(1, 17);
    end
    return 0;
  endfunction

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Global limit on the run.
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // Sampling at the rising edge: predict on input words, check output words.
  always @(posedge clk_i) begin
    conv_res_t got;
    conv_res_t want;
    in_fire  <= rst_ni && conv_in.valid && conv_in.ready;
    out_fire <= rst_ni && conv_out.valid && conv_out.ready;
    if (rst_ni && conv_in.valid && conv_in.ready) begin
      expected_q.push_back(hilbert_convert(order_reg, hcc_cmd_e'(conv_in.cmd),
                                           conv_in.in_x, conv_in.in_y, conv_in.in_index));
      accepted_cnt++;
    end
    if (rst_ni && conv_out.valid && conv_out.ready) begin
      got = '{conv_out.out_x, conv_out.out_y, conv_out.out_index};
      if (expected_q.size() == 0) begin
        $error("unexpected result word: x %0h y %0h index %0h", got.x, got.y, got.index);
        fail_cnt++;
      end else begin
        want = expected_q.pop_front();
        if (got.x !== want.x) begin
          $error("out_x: expected %0h, actual %0h", want.x, got.x);
          fail_cnt++;
        end
        if (got.y !== want.y) begin
          $error("out_y: expected %0h, actual %0h", want.y, got.y);
          fail_cnt++;
        end
        if (got.index !== want.index) begin
          $error("out_index: expected %0h, actual %0h", want.index, got.index);
          fail_cnt++;
        end
      end
    end
  end

  // Source side: offer pending words after their gap, optionally once drained.
  always @(negedge clk_i) begin
    int unsigned src_wait;
    conv_req_t   req;
    if (!rst_ni) begin
      conv_in.valid <= 1'b0;
      src_wait = 0;
    end else if (!conv_in.valid || in_fire) begin
      if (pending_q.size() != 0 && src_wait >= pending_q[0].gap &&
          !(pending_q[0].wait_drain && expected_q.size() != 0)) begin
        req = pending_q.pop_front();
        conv_in.valid    <= 1'b1;
        conv_in.cmd      <= req.cmd;
        conv_in.in_x     <= req.x;
        conv_in.in_y     <= req.y;
        conv_in.in_index <= req.index;
        src_wait = 0;
      end else begin
        conv_in.valid <= 1'b0;
        if (pending_q.size() != 0 && src_wait < pending_q[0].gap) begin
          src_wait++;
        end
      end
    end
  end

  // Sink side: a fresh random stall drawn after each result word, plus the long hold.
  always @(negedge clk_i) begin
    int unsigned snk_wait;
    if (!rst_ni) begin
      conv_out.ready <= 1'b0;
      snk_wait = 0;
    end else begin
      if (out_fire) begin
        snk_wait = draw_wait(snk_idle_on);
      end
      if (snk_wait != 0) begin
        snk_wait--;
        conv_out.ready <= 1'b0;
      end else begin
        conv_out.ready <= !snk_hold;
      end
    end
  end

  // Long output hold part way through, so that the pipeline fills and stalls.
  initial begin
    snk_hold = 1'b0;
    while (accepted_cnt < HoldStart) @(posedge clk_i);
    snk_hold = 1'b1;
    repeat (HoldTicks) @(posedge clk_i);
    snk_hold = 1'b0;
  end

  // Queue one request, with the source gap drawn now.
  task automatic push_req(hcc_cmd_e cmd, logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                          logic [IndexW-1:0] index, bit wait_drain);
    pending_q.push_back('{cmd, x, y, index, draw_wait(src_idle_on), wait_drain});
  endtask

  // Wait until every word has gone through, then let the pipeline settle.
  task automatic wait_idle();
    while (pending_q.size() != 0 || conv_in.valid || expected_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (FlushTicks) @(posedge clk_i);
  endtask

  // Register write followed by a read back of the same register.
  task automatic write_order(logic [4:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= OrderAddr;
    pwdata  <= DataW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    order_reg = value;
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== DataW'(value)) begin
      $error("prdata: expected %0h, actual %0h", DataW'(value), prdata);
      fail_cnt++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random requests with fields at full width, inside the order, or at extremes.
  task automatic push_random(int unsigned n, logic [4:0] ord);
    int unsigned       m;
    logic [CoordW-1:0] cm;
    logic [IndexW-1:0] im;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [IndexW-1:0] d;
    m  = (ord > MaxOrder) ? MaxOrder : ord;
    cm = CoordW'((32'd1 << m) - 32'd1);
    im = IndexW'((64'd1 << (2 * m)) - 64'd1);
    for (int unsigned i = 0; i < n; i++) begin
      x = CoordW'($urandom);
      y = CoordW'($urandom);
      d = $urandom;
      case ($urandom_range(0, 3))
        1: begin
          x = x & cm;
          y = y & cm;
          d = d & im;
        end
        2: begin
          x = {CoordW{x[0]}};
          y = {CoordW{y[0]}};
          d = {IndexW{d[0]}};
        end
        default: ;
      endcase
      push_req(hcc_cmd_e'($urandom_range(0, 1)), x, y, d, i == n / 2);
    end
  endtask

  // Stimulus: one set of requests per register setting.
  initial begin
    logic [4:0] orders[10];
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    conv_in.valid    = 1'b0;
    conv_in.cmd      = HCC_ENCODE;
    conv_in.in_x     = '0;
    conv_in.in_y     = '0;
    conv_in.in_index = '0;
    conv_out.ready   = 1'b0;
    order_reg        = 5'd16;
    fail_cnt         = 0;
    accepted_cnt     = 0;
    src_idle_on      = 1'b0;
    snk_idle_on      = 1'b0;
    orders = '{5'd16, 5'd0, 5'd1, 5'd3, 5'd31, 5'd7, 5'd16, 5'd17, 5'd2, 5'd15};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int p = 0; p < 10; p++) begin
      wait_idle();
      // The first set runs at the order left by reset.
      if (p != 0) begin
        write_order(orders[p]);
      end
      src_idle_on = (p % 4 != 0) && (p % 4 != 3);
      snk_idle_on = (p % 4 != 0);
      case (p)
        0: begin
          // Corners of the full grid and patterned indexes.
          push_req(HCC_ENCODE, 16'h0000, 16'h0000, '0, 1'b0);
          push_req(HCC_ENCODE, 16'hFFFF, 16'hFFFF, '0, 1'b0);
          push_req(HCC_ENCODE, 16'hFFFF, 16'h0000, '0, 1'b0);
          push_req(HCC_ENCODE, 16'h0000, 16'hFFFF, '0, 1'b0);
          push_req(HCC_ENCODE, 16'h8000, 16'h0001, '0, 1'b0);
          push_req(HCC_DECODE, '0, '0, 32'h0000_0000, 1'b0);
          push_req(HCC_DECODE, '0, '0, 32'hFFFF_FFFF, 1'b0);
          push_req(HCC_DECODE, '0, '0, 32'h5555_5555, 1'b0);
          push_req(HCC_DECODE, '0, '0, 32'hAAAA_AAAA, 1'b0);
          push_req(HCC_DECODE, '0, '0, 32'h8000_0000, 1'b0);
        end
        1: begin
          // Order zero: everything maps to the origin.
          push_req(HCC_ENCODE, 16'hFFFF, 16'hFFFF, '0, 1'b0);
          push_req(HCC_DECODE, '0, '0, 32'hFFFF_FFFF, 1'b0);
        end
        3: begin
          // High bits above the order are masked off.
          push_req(HCC_ENCODE, 16'hFFFD, 16'h0006, '0, 1'b0);
          push_req(HCC_DECODE, '0, '0, 32'hFFFF_FFC1, 1'b0);
        end
        4: begin
          // Order beyond the maximum saturates.
          push_req(HCC_ENCODE, 16'hFFFF, 16'h0000, '0, 1'b0);
          push_req(HCC_DECODE, '0, '0, 32'h1234_5678, 1'b0);
        end
        default: ;
      endcase
      push_random(RandPerSet, orders[p]);
    end

    wait_idle();
    if (fail_cnt == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
